// ===== hdl/qolt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qolt_pkg
// Types, constants and helpers shared by the line tokenizer modules.
// ----------------------------------------------------------------------------
package qolt_pkg;

  localparam int unsigned TokenMaxLen = 256;
  localparam int unsigned TokenLimit  = 16;
  localparam int unsigned LenW        = $clog2(TokenMaxLen + 1);
  localparam int unsigned CntW        = 5;
  localparam int unsigned IdxW        = 4;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QPtrW       = $clog2(QDepth);

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;

  typedef enum logic [2:0] {
    MODE_INIT = 3'd0,
    MODE_DQ   = 3'd1,
    MODE_UQ   = 3'd2,
    MODE_SQ   = 3'd4,
    MODE_SKIP = 3'd5
  } scan_mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_OK   = 2'd2,
    KIND_ERR  = 2'd3
  } res_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_BSLASH = 3'd1,
    ERR_LONG   = 3'd2,
    ERR_DQUOTE = 3'd3,
    ERR_SQUOTE = 3'd4,
    ERR_RESID  = 3'd5
  } err_e;

  // one classified byte: an optional token result, then an optional verdict
  typedef struct packed {
    logic             has_tok;
    logic             tok_end;
    logic [7:0]       tok_byte;
    logic [IdxW-1:0]  tok_idx;
    logic             has_vrd;
    err_e             vrd_err;
    logic [CntW-1:0]  vrd_count;
  } entry_t;

  function automatic logic is_gap(input logic [7:0] c);
    return (c == ChNul) || (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  function automatic logic esc_ok(input logic [7:0] c);
    return (c == ChBslash) || (c == ChDquote) || is_gap(c);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/quoted_option_line_tokenizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quoted_option_line_tokenizer
// Splits a zero-terminated byte stream into quoted shell-style tokens.
// ----------------------------------------------------------------------------
// a result is written into the queue as its byte is taken and shows on the output ports from the queue head
// throughput: one byte per cycle while the queue is not full; the scanner keeps all line state in registers
// a byte that closes a token and ends the line gives two results, two pops
// a four-entry queue between scanner and sequencer absorbs output stalls
// reset: asynchronous, clears the scanner and the queue; max_tokens returns to 16
module quoted_option_line_tokenizer import qolt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [7:0]      ch_i,
  input  wire logic            cfg_we_i,
  input  wire logic [CntW-1:0] max_tokens_i,
  output logic                 empty,
  input  wire logic            pop,
  output logic [1:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic [IdxW-1:0]      token_index_o,
  output logic [CntW-1:0]      token_count_o,
  output logic [2:0]           error_code_o,
  output logic                 last_o
);

  logic   q_full, q_empty;
  logic   byte_acc;
  entry_t f_ent;
  logic   f_valid;
  entry_t head;
  logic   head_pop;

  assign full     = q_full;
  assign byte_acc = push && !q_full;

  qolt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_acc),
    .ch_i         (ch_i),
    .cfg_we_i     (cfg_we_i),
    .max_tokens_i (max_tokens_i),
    .ent_o        (f_ent),
    .ent_valid_o  (f_valid)
  );

  qolt_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (f_valid),
    .wr_ent_i (f_ent),
    .rd_en_i  (head_pop),
    .rd_ent_o (head),
    .empty_o  (q_empty),
    .full_o   (q_full)
  );

  qolt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_empty_i  (q_empty),
    .head_pop_o    (head_pop),
    .pop           (pop),
    .empty         (empty),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .token_index_o (token_index_o),
    .token_count_o (token_count_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

endmodule
`default_nettype wire

// ===== hdl/qolt_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qolt_front
// Scanner state machine: classifies each accepted byte and builds one entry.
// ----------------------------------------------------------------------------
module qolt_front import qolt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            byte_valid_i,
  input  wire logic [7:0]      ch_i,
  input  wire logic            cfg_we_i,
  input  wire logic [CntW-1:0] max_tokens_i,
  output entry_t               ent_o,
  output logic                 ent_valid_o
);

  scan_mode_e      mode_q, mode_d;
  logic            esc_q, esc_d;
  logic [LenW-1:0] len_q, len_d;
  logic [CntW-1:0] tokd_q, tokd_d;
  err_e            perr_q, perr_d;
  logic [CntW-1:0] max_tok_q;
  logic [CntW-1:0] lim;

  assign lim = (max_tok_q > CntW'(TokenLimit)) ? CntW'(TokenLimit) : max_tok_q;

  always_comb begin : step
    scan_mode_e      m;
    logic            esc;
    logic [LenW-1:0] len;
    logic [CntW-1:0] tokd;
    err_e            perr;
    logic [7:0]      oc;
    logic            done;
    logic            comment;
    logic            stop;
    err_e            code;
    entry_t          ent;

    m       = mode_q;
    esc     = esc_q;
    len     = len_q;
    tokd    = tokd_q;
    perr    = perr_q;
    oc      = ChNul;
    done    = 1'b0;
    comment = 1'b0;
    stop    = 1'b0;
    code    = ERR_NONE;
    ent     = '0;

    if (mode_q == MODE_SKIP) begin
      if (ch_i == ChNul) begin
        ent.has_vrd   = 1'b1;
        ent.vrd_err   = perr_q;
        ent.vrd_count = tokd_q;
        m    = MODE_INIT;
        esc  = 1'b0;
        len  = '0;
        tokd = '0;
        perr = ERR_NONE;
      end
    end else begin
      if (!esc_q && (ch_i == ChBslash) && (mode_q != MODE_SQ)) begin
        esc = 1'b1;
      end else begin
        case (mode_q)
          MODE_INIT: begin
            if (!is_gap(ch_i)) begin
              if ((ch_i == ChSemi) || (ch_i == ChHash)) begin
                comment = 1'b1;
              end else if (!esc_q && (ch_i == ChDquote)) begin
                m = MODE_DQ;
              end else if (!esc_q && (ch_i == ChSquote)) begin
                m = MODE_SQ;
              end else begin
                oc = ch_i;
                m  = MODE_UQ;
              end
            end
          end
          MODE_UQ: begin
            if (!esc_q && is_gap(ch_i)) done = 1'b1;
            else oc = ch_i;
          end
          MODE_DQ: begin
            if (!esc_q && (ch_i == ChDquote)) done = 1'b1;
            else oc = ch_i;
          end
          MODE_SQ: begin
            if (ch_i == ChSquote) done = 1'b1;
            else oc = ch_i;
          end
          default: begin
          end
        endcase

        if (done) begin
          ent.has_tok = 1'b1;
          ent.tok_end = 1'b1;
          ent.tok_idx = tokd_q[IdxW-1:0];
          tokd        = tokd_q + CntW'(1);
          m           = MODE_INIT;
          len         = '0;
        end

        // comment and bad escape both drop into skip
        if (comment) begin
          m    = MODE_SKIP;
          esc  = 1'b0;
          perr = ERR_NONE;
          stop = 1'b1;
        end else if (esc_q && (oc != ChNul) && !esc_ok(oc)) begin
          m    = MODE_SKIP;
          esc  = 1'b0;
          perr = ERR_BSLASH;
          stop = 1'b1;
        end else begin
          esc = 1'b0;
        end
      end

      if (!stop && (oc != ChNul)) begin
        if (len_q >= LenW'(TokenMaxLen)) begin
          m    = MODE_SKIP;
          esc  = 1'b0;
          perr = ERR_LONG;
          stop = 1'b1;
        end else begin
          ent.has_tok  = 1'b1;
          ent.tok_end  = 1'b0;
          ent.tok_byte = oc;
          ent.tok_idx  = tokd[IdxW-1:0];
          len          = len_q + LenW'(1);
        end
      end

      if (!stop && ((tokd >= lim) || (ch_i == ChNul))) begin
        if (m == MODE_DQ) code = ERR_DQUOTE;
        else if (m == MODE_SQ) code = ERR_SQUOTE;
        else if (m != MODE_INIT) code = ERR_RESID;
        else code = ERR_NONE;
        if (ch_i == ChNul) begin
          ent.has_vrd   = 1'b1;
          ent.vrd_err   = code;
          ent.vrd_count = tokd;
          m    = MODE_INIT;
          esc  = 1'b0;
          len  = '0;
          tokd = '0;
          perr = ERR_NONE;
        end else begin
          m    = MODE_SKIP;
          esc  = 1'b0;
          perr = code;
        end
      end
    end

    mode_d      = m;
    esc_d       = esc;
    len_d       = len;
    tokd_d      = tokd;
    perr_d      = perr;
    ent_o       = ent;
    ent_valid_o = byte_valid_i && (ent.has_tok || ent.has_vrd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_INIT;
      esc_q     <= 1'b0;
      len_q     <= '0;
      tokd_q    <= '0;
      perr_q    <= ERR_NONE;
      max_tok_q <= CntW'(TokenLimit);
    end else begin
      if (byte_valid_i) begin
        mode_q <= mode_d;
        esc_q  <= esc_d;
        len_q  <= len_d;
        tokd_q <= tokd_d;
        perr_q <= perr_d;
      end
      if (cfg_we_i) begin
        max_tok_q <= max_tokens_i;
      end
    end
  end

  a_skip_no_esc : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_SKIP) |-> !esc_q)
    else $error("escape pending while skipping");

  a_tokd_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tokd_q <= CntW'(TokenLimit))
    else $error("token count beyond limit");

  a_len_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(TokenMaxLen))
    else $error("token length beyond maximum");

endmodule
`default_nettype wire

// ===== hdl/qolt_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qolt_fifo
// Short entry queue between the scanner and the result sequencer.
// ----------------------------------------------------------------------------
module qolt_fifo import qolt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_en_i,
  input  entry_t       wr_ent_i,
  input  wire logic    rd_en_i,
  output entry_t       rd_ent_o,
  output logic         empty_o,
  output logic         full_o
);

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q, wptr_d;
  logic [QPtrW-1:0]  rptr_q, rptr_d;
  logic [QPtrW:0]    cnt_q, cnt_d;
  logic              do_wr, do_rd;

  assign empty_o  = (cnt_q == '0);
  assign full_o   = (cnt_q == (QPtrW+1)'(QDepth));
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && !empty_o;
  assign rd_ent_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? wptr_q + QPtrW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + QPtrW'(1) : rptr_q;
    cnt_d  = cnt_q + (QPtrW+1)'(do_wr) - (QPtrW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_ent_i;
    end
  end

  a_ptr_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != (QPtrW+1)'(QDepth) && cnt_q != '0) |-> (wptr_q != rptr_q))
    else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

// ===== hdl/qolt_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qolt_back
// Result sequencer: expands each queued entry into one or two results.
// ----------------------------------------------------------------------------
module qolt_back import qolt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  entry_t               head_i,
  input  wire logic            head_empty_i,
  output logic                 head_pop_o,
  input  wire logic            pop,
  output logic                 empty,
  output logic [1:0]           kind_o,
  output logic [7:0]           out_byte_o,
  output logic [IdxW-1:0]      token_index_o,
  output logic [CntW-1:0]      token_count_o,
  output logic [2:0]           error_code_o,
  output logic                 last_o
);

  logic      sel_q, sel_d;
  logic      show_tok;
  logic      take;
  res_kind_e kind;

  // sel_q set: token part already taken, verdict part on the ports
  assign show_tok = head_i.has_tok && !sel_q;
  assign empty    = head_empty_i;
  assign take     = pop && !head_empty_i;

  always_comb begin
    if (show_tok) begin
      kind = head_i.tok_end ? KIND_END : KIND_BYTE;
    end else begin
      kind = (head_i.vrd_err == ERR_NONE) ? KIND_OK : KIND_ERR;
    end
    kind_o        = kind;
    out_byte_o    = (show_tok && !head_i.tok_end) ? head_i.tok_byte : 8'h00;
    token_index_o = show_tok ? head_i.tok_idx : '0;
    token_count_o = (kind == KIND_OK) ? head_i.vrd_count : '0;
    error_code_o  = (kind == KIND_ERR) ? head_i.vrd_err : ERR_NONE;
    last_o        = !show_tok || !head_i.has_vrd;
  end

  always_comb begin
    sel_d      = sel_q;
    head_pop_o = 1'b0;
    if (take) begin
      if (show_tok && head_i.has_vrd) begin
        sel_d = 1'b1;
      end else begin
        sel_d      = 1'b0;
        head_pop_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  a_sel_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (!head_empty_i && head_i.has_tok && head_i.has_vrd))
    else $error("verdict half selected on an entry without two results");

endmodule
`default_nettype wire

// ===== tb/tb_quoted_option_line_tokenizer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_option_line_tokenizer
// Streams zero-terminated lines into the tokenizer under random flow control,
// predicts every token byte, token end and line verdict, and compares them in
// order with what the block pops out.
// ----------------------------------------------------------------------------
module tb_quoted_option_line_tokenizer;
  import qolt_pkg::*;

  localparam int unsigned StallCycles = 300;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned ShowMax     = 10;

  typedef struct {
    res_kind_e       kind;
    logic [7:0]      chr;
    logic [IdxW-1:0] idx;
    logic [CntW-1:0] cnt;
    err_e            err;
    logic            last;
  } tok_result_t;

  logic            clk_i        = 1'b0;
  logic            rst_ni       = 1'b0;
  logic            push         = 1'b0;
  logic            full;
  logic [7:0]      ch_i         = '0;
  logic            cfg_we_i     = 1'b0;
  logic [CntW-1:0] max_tokens_i = '0;
  logic            empty;
  logic            pop          = 1'b0;
  logic [1:0]      kind_o;
  logic [7:0]      out_byte_o;
  logic [IdxW-1:0] token_index_o;
  logic [CntW-1:0] token_count_o;
  logic [2:0]      error_code_o;
  logic            last_o;

  // line state of the predictor
  scan_mode_e      line_mode;
  logic            esc_armed;
  int unsigned     tok_len;
  int unsigned     tok_seen;
  err_e            held_err;
  logic [CntW-1:0] max_tok;
  tok_result_t     step_q[$];
  tok_result_t     pending_results[$];

  int unsigned     mismatches    = 0;
  int unsigned     bytes_sent    = 0;
  int unsigned     quiet_cycles  = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     stall_left    = 0;
  logic            stall_req     = 1'b0;

  quoted_option_line_tokenizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .ch_i          (ch_i),
    .cfg_we_i      (cfg_we_i),
    .max_tokens_i  (max_tokens_i),
    .empty         (empty),
    .pop           (pop),
    .kind_o        (kind_o),
    .out_byte_o    (out_byte_o),
    .token_index_o (token_index_o),
    .token_count_o (token_count_o),
    .error_code_o  (error_code_o),
    .last_o        (last_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(input logic [7:0] c);
    return c inside {ChNul, ChSpace, [ChTab:ChCr]};
  endfunction

  function automatic bit escapable(input logic [7:0] c);
    return c == ChBslash || c == ChDquote || is_blank(c);
  endfunction

  function automatic void clear_line();
    line_mode = MODE_INIT;
    esc_armed = 1'b0;
    tok_len   = 0;
    tok_seen  = 0;
    held_err  = ERR_NONE;
  endfunction

  function automatic void emit(input res_kind_e k, input logic [7:0] b,
                               input logic [IdxW-1:0] i, input logic [CntW-1:0] n,
                               input err_e e);
    tok_result_t r;
    r.kind = k;
    r.chr  = b;
    r.idx  = i;
    r.cnt  = n;
    r.err  = e;
    r.last = 1'b0;
    step_q.push_back(r);
  endfunction

  function automatic void close_line(input err_e code);
    if (code == ERR_NONE) begin
      emit(KIND_OK, ChNul, '0, CntW'(tok_seen), ERR_NONE);
    end else begin
      emit(KIND_ERR, ChNul, '0, '0, code);
    end
    clear_line();
  endfunction

  // rest of the line is skipped, the saved verdict comes with the zero byte
  function automatic void abort_line(input err_e code);
    held_err  = code;
    line_mode = MODE_SKIP;
    esc_armed = 1'b0;
  endfunction

  function automatic void tokenize_byte(input logic [7:0] c);
    logic [7:0]  oc;
    logic        closed;
    logic        halted;
    int unsigned lim;
    err_e        code;
    oc     = ChNul;
    closed = 1'b0;
    halted = 1'b0;
    lim    = (max_tok > TokenLimit) ? TokenLimit : max_tok;
    step_q.delete();
    if (line_mode == MODE_SKIP) begin
      if (c == ChNul) close_line(held_err);
    end else begin
      if (!esc_armed && c == ChBslash && line_mode != MODE_SQ) begin
        esc_armed = 1'b1;
      end else begin
        case (line_mode)
          MODE_INIT: begin
            if (!is_blank(c)) begin
              if (c == ChSemi || c == ChHash) begin
                abort_line(ERR_NONE);
                halted = 1'b1;
              end else if (!esc_armed && c == ChDquote) begin
                line_mode = MODE_DQ;
              end else if (!esc_armed && c == ChSquote) begin
                line_mode = MODE_SQ;
              end else begin
                oc        = c;
                line_mode = MODE_UQ;
              end
            end
          end
          MODE_UQ: begin
            if (!esc_armed && is_blank(c)) closed = 1'b1;
            else oc = c;
          end
          MODE_DQ: begin
            if (!esc_armed && c == ChDquote) closed = 1'b1;
            else oc = c;
          end
          default: begin
            if (c == ChSquote) closed = 1'b1;
            else oc = c;
          end
        endcase
        if (!halted) begin
          if (closed) begin
            emit(KIND_END, ChNul, IdxW'(tok_seen), '0, ERR_NONE);
            tok_seen++;
            line_mode = MODE_INIT;
            tok_len   = 0;
          end
          if (esc_armed && oc != ChNul && !escapable(oc)) begin
            abort_line(ERR_BSLASH);
            halted = 1'b1;
          end
          esc_armed = 1'b0;
        end
      end
      if (!halted && oc != ChNul) begin
        if (tok_len >= TokenMaxLen) begin
          abort_line(ERR_LONG);
          halted = 1'b1;
        end else begin
          emit(KIND_BYTE, oc, IdxW'(tok_seen), '0, ERR_NONE);
          tok_len++;
        end
      end
      // verdict is fixed from the mode when the line ends or the limit is hit
      if (!halted && (tok_seen >= lim || c == ChNul)) begin
        if (line_mode == MODE_DQ) code = ERR_DQUOTE;
        else if (line_mode == MODE_SQ) code = ERR_SQUOTE;
        else if (line_mode != MODE_INIT) code = ERR_RESID;
        else code = ERR_NONE;
        if (c == ChNul) close_line(code);
        else abort_line(code);
      end
    end
    if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) pending_results.push_back(step_q[i]);
  endfunction

  // ------------------------------------------------------- monitor and checks

  always @(posedge clk_i) begin : result_check
    tok_result_t want;
    if (!rst_ni) begin
      max_tok = CntW'(TokenLimit);
      clear_line();
    end else begin
      // a byte taken at the same edge as a register write sees the old limit
      if (push && !full) tokenize_byte(ch_i);
      if (cfg_we_i) max_tok = max_tokens_i;
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= ShowMax) begin
            $display("unexpected result: kind %0d byte %02h index %0d count %0d error %0d",
                     kind_o, out_byte_o, token_index_o, token_count_o, error_code_o);
          end
        end else begin
          want = pending_results.pop_front();
          if (kind_o !== want.kind || out_byte_o !== want.chr ||
              token_index_o !== want.idx || token_count_o !== want.cnt ||
              error_code_o !== want.err || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= ShowMax) begin
              $display("mismatch: expected kind %0d byte %02h index %0d count %0d error %0d last %0d",
                       want.kind, want.chr, want.idx, want.cnt, want.err, want.last);
              $display("          actual   kind %0d byte %02h index %0d count %0d error %0d last %0d",
                       kind_o, out_byte_o, token_index_o, token_count_o, error_code_o, last_o);
            end
          end
        end
      end
    end
  end

  // receiver: random pops, or a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_req) begin
      stall_left = StallCycles;
      stall_req  = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------ drivers

  // push stays high between back-to-back transactions
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_line(input string text);
    for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    send_byte(ChNul);
  endtask

  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    // skipped bytes give no result but may still be in flight
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_max_tokens(input logic [CntW-1:0] v);
    cfg_we_i     <= 1'b1;
    max_tokens_i <= v;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'hFF));
    while (c inside {ChDquote, ChSquote, ChBslash, ChSemi, ChHash});
    return c;
  endfunction

  function automatic logic [7:0] gap_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? ChSpace : ChTab + 8'(k);
  endfunction

  function automatic logic [7:0] loose_char();
    case ($urandom_range(9))
      0: return ChSemi;
      1: return ChHash;
      2: return ChSquote;
      3: return ChSpace;
      default: return plain_char();
    endcase
  endfunction

  function automatic logic [7:0] squote_char();
    logic [7:0] c;
    case ($urandom_range(9))
      0: return ChBslash;
      1: return ChDquote;
      default: begin
        do c = 8'($urandom_range(1, 255));
        while (c == ChSquote);
        return c;
      end
    endcase
  endfunction

  task automatic send_token();
    int unsigned n;
    n = $urandom_range(0, 6);
    case ($urandom_range(3))
      0: begin
        send_byte(ChDquote);
        repeat (n) begin
          if ($urandom_range(5) == 0) begin
            send_byte(ChBslash);
            send_byte($urandom_range(1) ? ChBslash : ChDquote);
          end else begin
            send_byte(loose_char());
          end
        end
        send_byte(ChDquote);
      end
      1: begin
        send_byte(ChSquote);
        repeat (n) send_byte(squote_char());
        send_byte(ChSquote);
      end
      default: begin
        repeat (n + 1) begin
          if ($urandom_range(6) == 0) begin
            send_byte(ChBslash);
            send_byte($urandom_range(1) ? ChBslash : gap_char());
          end else begin
            send_byte(loose_char());
          end
        end
      end
    endcase
  endtask

  task automatic send_random_line();
    int unsigned ntok;
    // some lines are pure noise
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(0, 20)) send_byte(8'($urandom_range(1, 255)));
      send_byte(ChNul);
      return;
    end
    ntok = $urandom_range(0, 5);
    if ($urandom_range(7) == 0) ntok += $urandom_range(6, 14);
    if ($urandom_range(1) == 0) send_byte(gap_char());
    for (int t = 0; t < ntok; t++) begin
      if (t != 0 && $urandom_range(9) != 0) begin
        repeat ($urandom_range(1, 2)) send_byte(gap_char());
      end
      send_token();
    end
    case ($urandom_range(19))
      0, 1: begin
        send_byte(gap_char());
        send_byte($urandom_range(1) ? ChSemi : ChHash);
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(1, 255)));
      end
      2: begin
        send_byte(ChBslash);
        send_byte(plain_char());
      end
      3: begin
        send_byte(gap_char());
        send_byte(ChDquote);
        send_byte(plain_char());
      end
      4: begin
        send_byte(gap_char());
        send_byte(ChSquote);
        send_byte(plain_char());
      end
      5: begin
        send_byte(plain_char());
        send_byte(ChBslash);
      end
      6, 7: send_byte(gap_char());
      default: ;
    endcase
    send_byte(ChNul);
  endtask

  function automatic logic [CntW-1:0] pick_limit();
    if ($urandom_range(9) < 3) return CntW'($urandom_range(0, 3));
    return CntW'($urandom_range(4, 31));
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_quoting();
    send_line("");
    send_line("a\\ b\t\"\\\"\"\n'\\'");
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(ChNul);
  endtask

  task automatic test_comments();
    send_line("x;y #");
  endtask

  task automatic test_errors();
    send_line("\\'");
    send_line("\"");
    send_line("'");
    send_line("x\\");
  endtask

  task automatic test_long_token();
    repeat (TokenMaxLen) send_byte(plain_char());
    send_byte(ChSpace);
    repeat (TokenMaxLen + 1) send_byte(plain_char());
    send_byte(ChNul);
    drain();
  endtask

  task automatic test_token_limit();
    drain();
    set_max_tokens(5'd1);
    send_line("a b c");
    drain();
    set_max_tokens(5'd0);
    send_line("ab");
    send_line("");
    drain();
    set_max_tokens(5'd31);
    send_line("a b c d e f g h i j k l m n o p q r");
    drain();
    set_max_tokens(CntW'(TokenLimit));
  endtask

  task automatic test_backpressure();
    drain();
    stall_req = 1'b1;
    send_line("alpha \"beta gamma\" 'delta' eps");
    send_line("zeta eta theta");
    drain();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned lines;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at       = bytes_sent + n_bytes;
    lines         = 0;
    while (bytes_sent < stop_at) begin
      if (lines % 40 == 0) begin
        drain();
        set_max_tokens(pick_limit());
      end
      send_random_line();
      lines++;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 29;
    recv_idle_pct = 82;
    test_quoting();
    test_comments();
    test_errors();
    test_long_token();
    test_token_limit();
    test_backpressure();
    test_random_traffic(29, 82, 305);
    test_random_traffic(82, 29, 305);
    test_random_traffic(0, 0, 300);
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
